// ===== hdl/owbm_pkg.sv =====
// Shared types, codes and defaults for the one-wire bus master.
// No dependencies; imported by every module of the block.
`default_nettype none

package owbm_pkg;

	// Bits sent or read by a byte command.
	localparam int BITS_PER_BYTE_DEFAULT = 8;

	// Command codes on the input channel.
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_RESET     = 3'd1;
	localparam logic [2:0] OP_WRITE     = 3'd2;
	localparam logic [2:0] OP_READ_BYTE = 3'd3;
	localparam logic [2:0] OP_READ_BIT  = 3'd4;

	// Configuration register indexes (byte address is 4 * index).
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
	localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
	localparam logic [2:0] REG_RECOVERY      = 3'd5;
	localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [2:0] REG_READ_TAIL     = 3'd7;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int TIMER_W    = 10;

	// Register defaults.
	localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
	localparam logic [8:0] PRESENCE_WAIT_DEFAULT = 9'd100;
	localparam logic [8:0] RESET_TAIL_DEFAULT    = 9'd380;
	localparam logic [3:0] SLOT_LOW_DEFAULT      = 4'd2;
	localparam logic [6:0] WRITE_HOLD_DEFAULT    = 7'd58;
	localparam logic [3:0] RECOVERY_DEFAULT      = 4'd1;
	localparam logic [5:0] READ_SAMPLE_DEFAULT   = 6'd10;
	localparam logic [6:0] READ_TAIL_DEFAULT     = 7'd49;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_SLOT_LOW,
		PH_SLOT_MID,
		PH_SLOT_END
	} phase_t;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [8:0] presence_wait_time;
		logic [8:0] reset_tail_time;
		logic [3:0] slot_low_time;
		logic [6:0] write_hold_time;
		logic [3:0] recovery_time;
		logic [5:0] read_sample_time;
		logic [6:0] read_tail_time;
	} owbm_cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence;
	} owbm_res_t;

	// A zero timing register counts as one tick.
	function automatic logic [TIMER_W-1:0] span(input logic [TIMER_W-1:0] v);
		return (v == '0) ? TIMER_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/owbm_cmd_if.sv =====
// Input channel of the one-wire bus master: one tick item per handshake.
// Depends on nothing.
`default_nettype none

interface owbm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] write_data;
	logic       line_in;

	modport source (output valid, output cmd, output write_data, output line_in, input ready);
	modport sink (input valid, input cmd, input write_data, input line_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/owbm_res_if.sv =====
// Result channel of the one-wire bus master: one result item per tick.
// Depends on nothing.
`default_nettype none

interface owbm_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       presence;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output read_data, output presence, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input read_data, input presence, output ready);
endinterface

`default_nettype wire

// ===== hdl/owbm_apb_regs.sv =====
// APB-style register file holding the eight bus timing registers.
// Depends on owbm_pkg.
`default_nettype none

module owbm_apb_regs
	import owbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output owbm_cfg_t             cfg
);

	owbm_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time     <= RESET_LOW_DEFAULT;
			cfg_q.presence_wait_time <= PRESENCE_WAIT_DEFAULT;
			cfg_q.reset_tail_time    <= RESET_TAIL_DEFAULT;
			cfg_q.slot_low_time      <= SLOT_LOW_DEFAULT;
			cfg_q.write_hold_time    <= WRITE_HOLD_DEFAULT;
			cfg_q.recovery_time      <= RECOVERY_DEFAULT;
			cfg_q.read_sample_time   <= READ_SAMPLE_DEFAULT;
			cfg_q.read_tail_time     <= READ_TAIL_DEFAULT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RESET_LOW:     cfg_q.reset_low_time     <= pwdata[9:0];
				REG_PRESENCE_WAIT: cfg_q.presence_wait_time <= pwdata[8:0];
				REG_RESET_TAIL:    cfg_q.reset_tail_time    <= pwdata[8:0];
				REG_SLOT_LOW:      cfg_q.slot_low_time      <= pwdata[3:0];
				REG_WRITE_HOLD:    cfg_q.write_hold_time    <= pwdata[6:0];
				REG_RECOVERY:      cfg_q.recovery_time      <= pwdata[3:0];
				REG_READ_SAMPLE:   cfg_q.read_sample_time   <= pwdata[5:0];
				REG_READ_TAIL:     cfg_q.read_tail_time     <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RESET_LOW:     prdata = APB_DATA_W'(cfg_q.reset_low_time);
			REG_PRESENCE_WAIT: prdata = APB_DATA_W'(cfg_q.presence_wait_time);
			REG_RESET_TAIL:    prdata = APB_DATA_W'(cfg_q.reset_tail_time);
			REG_SLOT_LOW:      prdata = APB_DATA_W'(cfg_q.slot_low_time);
			REG_WRITE_HOLD:    prdata = APB_DATA_W'(cfg_q.write_hold_time);
			REG_RECOVERY:      prdata = APB_DATA_W'(cfg_q.recovery_time);
			REG_READ_SAMPLE:   prdata = APB_DATA_W'(cfg_q.read_sample_time);
			REG_READ_TAIL:     prdata = APB_DATA_W'(cfg_q.read_tail_time);
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/owbm_tick_engine.sv =====
// Slot sequencer of the one-wire bus master: bus state plus the logic of one tick.
// Depends on owbm_pkg.
`default_nettype none

module owbm_tick_engine
	import owbm_pkg::*;
#(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [2:0] cmd,
	input  logic [7:0] write_data,
	input  logic       line_in,
	input  owbm_cfg_t  cfg,
	output owbm_res_t  res
);

	localparam int BL_W = $clog2(BITS_PER_BYTE + 1);

	phase_t             phase_q, ph_e, ph_n;
	logic [2:0]         op_q, op_e;
	logic [TIMER_W-1:0] timer_q, tmr_e, tmr_n;
	logic [BL_W-1:0]    bits_q, bits_e, bits_n;
	logic [7:0]         shift_q, sr_e, sr_n, sr_fill;
	logic               presence_q, pf_n;
	logic               start, last, finish, op_write;

	// Pick up a new command when idle; it starts its first phase this tick.
	always_comb begin
		start = (phase_q == PH_IDLE) && (cmd == OP_RESET || cmd == OP_WRITE ||
			cmd == OP_READ_BYTE || cmd == OP_READ_BIT);
		ph_e   = phase_q;
		op_e   = op_q;
		tmr_e  = timer_q;
		bits_e = bits_q;
		sr_e   = shift_q;
		if (start) begin
			op_e = cmd;
			if (cmd == OP_RESET) begin
				ph_e  = PH_RST_LOW;
				tmr_e = span(cfg.reset_low_time);
			end else begin
				ph_e   = PH_SLOT_LOW;
				tmr_e  = span(TIMER_W'(cfg.slot_low_time));
				bits_e = (cmd == OP_READ_BIT) ? BL_W'(1) : BL_W'(BITS_PER_BYTE);
				sr_e   = (cmd == OP_WRITE) ? write_data : 8'd0;
			end
		end
	end

	assign op_write = (op_e == OP_WRITE);
	assign last     = (tmr_e <= TIMER_W'(1));
	assign finish   = last && ((ph_e == PH_RST_TAIL) ||
		(ph_e == PH_SLOT_END && bits_e <= BL_W'(1)));

	// Read bits enter at the top of the byte and move toward bit 0.
	always_comb begin
		sr_fill = {1'b0, sr_e[7:1]};
		sr_fill[BITS_PER_BYTE-1] = sr_fill[BITS_PER_BYTE-1] | line_in;
	end

	// Next state
	always_comb begin
		ph_n   = ph_e;
		tmr_n  = last ? tmr_e : tmr_e - TIMER_W'(1);
		bits_n = bits_e;
		sr_n   = sr_e;
		pf_n   = presence_q;
		unique case (ph_e)
			PH_RST_LOW: begin
				if (last) begin
					ph_n  = PH_RST_WAIT;
					tmr_n = span(TIMER_W'(cfg.presence_wait_time));
				end
			end
			PH_RST_WAIT: begin
				if (last) begin
					pf_n  = ~line_in;
					ph_n  = PH_RST_TAIL;
					tmr_n = span(TIMER_W'(cfg.reset_tail_time));
				end
			end
			PH_SLOT_LOW: begin
				if (last) begin
					ph_n  = PH_SLOT_MID;
					tmr_n = op_write ? span(TIMER_W'(cfg.write_hold_time))
						: span(TIMER_W'(cfg.read_sample_time));
				end
			end
			PH_SLOT_MID: begin
				if (last) begin
					if (!op_write) begin
						sr_n = (op_e == OP_READ_BIT) ? {7'd0, line_in} : sr_fill;
					end
					ph_n  = PH_SLOT_END;
					tmr_n = op_write ? span(TIMER_W'(cfg.recovery_time))
						: span(TIMER_W'(cfg.read_tail_time));
				end
			end
			PH_SLOT_END: begin
				if (last) begin
					if (op_write) begin
						sr_n = {1'b0, sr_e[7:1]};
					end
					if (bits_e <= BL_W'(1)) begin
						bits_n = '0;
					end else begin
						bits_n = bits_e - BL_W'(1);
						ph_n   = PH_SLOT_LOW;
						tmr_n  = span(TIMER_W'(cfg.slot_low_time));
					end
				end
			end
			default: ;
		endcase
		if (finish) begin
			ph_n  = PH_IDLE;
			tmr_n = '0;
		end
	end

	// Outputs
	always_comb begin
		res.drive_low = (ph_e == PH_RST_LOW) || (ph_e == PH_SLOT_LOW) ||
			(ph_e == PH_SLOT_MID && op_write && !sr_e[0]);
		res.busy_res  = (ph_e != PH_IDLE);
		res.done_res  = finish;
		res.read_data = (finish && (op_e == OP_READ_BYTE || op_e == OP_READ_BIT))
			? sr_e : 8'd0;
		res.presence  = pf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			op_q       <= OP_TICK;
			timer_q    <= '0;
			bits_q     <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= ph_n;
			op_q       <= op_e;
			timer_q    <= tmr_n;
			bits_q     <= bits_n;
			shift_q    <= sr_n;
			presence_q <= pf_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/one_wire_bus_master.sv =====
// One-wire bus master, top level: tick pipeline around the slot sequencer.
// Depends on owbm_pkg, owbm_cmd_if, owbm_res_if, owbm_apb_regs, owbm_tick_engine.
//
// Usage
//   cmd_ch carries one item per microsecond tick: the sampled bus level
//   (line_in) and, while the master is idle, a command (reset and presence,
//   write byte, read byte, read bit); write_data goes with a write command.
//   res_ch returns one item per tick: drive_low for the open-drain pad,
//   busy_res, done_res on the final tick of a command, read_data on that
//   tick, and the presence flag from the last reset.
//   Timing registers sit on the APB port at byte address 4 * index; write
//   them only while no command runs.
// Pipeline and throughput
//   An accepted item is registered in the input stage, runs through the slot
//   sequencer as it moves on, and its result is registered in the result stage.
//   One item per cycle is sustained while the receiver keeps taking results; the
//   input register and the result register each hold one item, so a stalled receiver
//   backs up into the input stage and drops cmd_ch.ready only once both are full.
// Reset
//   arst_n clears both pipeline stages, the sequencer (idle, no presence)
//   and restores the default bus timings.
`default_nettype none

module one_wire_bus_master
	import owbm_pkg::*;
#(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	owbm_cmd_if.sink              cmd_ch,
	owbm_res_if.source            res_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	owbm_cfg_t  cfg;
	owbm_res_t  res_comb;
	owbm_res_t  res_s2;
	logic       valid_s1, valid_s2;
	logic [2:0] cmd_s1;
	logic [7:0] write_data_s1;
	logic       line_in_s1;
	logic       take_s2, adv_s1, take_s1;

	owbm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register frees up when empty or when its item is taken.
	assign take_s2 = !valid_s2 || res_ch.ready;
	// The input-stage item steps the sequencer only as it moves on.
	assign adv_s1  = valid_s1 && take_s2;
	assign cmd_ch.ready = !valid_s1 || take_s2;
	assign take_s1 = cmd_ch.valid && cmd_ch.ready;

	// Input stage: hold the tick item until the sequencer consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			cmd_s1        <= cmd_ch.cmd;
			write_data_s1 <= cmd_ch.write_data;
			line_in_s1    <= cmd_ch.line_in;
		end
	end

	owbm_tick_engine #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv_s1),
		.cmd        (cmd_s1),
		.write_data (write_data_s1),
		.line_in    (line_in_s1),
		.cfg        (cfg),
		.res        (res_comb)
	);

	// Result stage: hold the result item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_ch.valid     = valid_s2;
	assign res_ch.drive_low = res_s2.drive_low;
	assign res_ch.busy_res  = res_s2.busy_res;
	assign res_ch.done_res  = res_s2.done_res;
	assign res_ch.read_data = res_s2.read_data;
	assign res_ch.presence  = res_s2.presence;

	// A finishing tick always belongs to a running command.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> res_s2.busy_res)
		else $error("done without busy");

	// Read data shows only on the finishing tick.
	a_rd_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.read_data != 8'd0 |-> res_s2.done_res)
		else $error("read data outside done tick");

	// The bus is only pulled low during a command.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.drive_low |-> res_s2.busy_res)
		else $error("bus driven while idle");

	// Input back-pressure only when both stages are full and stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ch.ready |-> valid_s1 && valid_s2 && !res_ch.ready)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for one_wire_bus_master: a tick-accurate predictor of the slot
// sequencer checks every result item, over directed and random bus traffic.
// Depends on owbm_pkg, owbm_cmd_if, owbm_res_if and the one_wire_bus_master RTL.
`default_nettype none

module testbench;
	import owbm_pkg::*;

	// Highest code the cmd field can carry; codes above OP_READ_BIT act as plain ticks.
	localparam logic [2:0] OP_LAST_CODE = 3'd7;
	localparam int BYTE_BITS = BITS_PER_BYTE_DEFAULT;
	localparam int RANDOM_TICKS = 850;
	// Slowest correct run: about 2000 ticks, plus a few thousand more when a random batch
	// draws long timings, each paying a full sender gap and a full receiver stall, plus
	// register traffic and one long hold. Allow several times that.
	localparam longint TIMEOUT_CYCLES = 2_000_000;

	typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_e;
	typedef enum {PICK_ZERO, PICK_ONE, PICK_MAX, PICK_DEFAULT, PICK_SMALL, PICK_MIXED}
		timing_pick_e;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	owbm_cmd_if cmd_ch();
	owbm_res_if res_ch();

	one_wire_bus_master DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.res_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Shadow of the timing registers and of the slot sequencer state.
	logic [9:0] timing [8];
	phase_t     seq_phase = PH_IDLE;
	logic [2:0] seq_op = OP_TICK;
	logic [9:0] slot_left = '0;
	int         bits_to_go = 0;
	logic [7:0] shifter = '0;
	logic       present = 1'b0;

	// Bus results still owed by the block, oldest first.
	owbm_res_t  bus_results_due [$];

	// Knobs shared between the test tasks and the result checker.
	int tx_gap_max = 0;
	int rx_gap_max = 0;
	int rx_hold_cycles = 0;

	int unsigned fail_count = 0;
	int unsigned ticks_sent = 0;
	int unsigned results_checked = 0;
	int unsigned n_resets = 0;
	int unsigned n_writes = 0;
	int unsigned n_read_bytes = 0;
	int unsigned n_read_bits = 0;

	function automatic int reg_width(input logic [2:0] idx);
		case (idx)
			REG_RESET_LOW: return 10;
			REG_PRESENCE_WAIT, REG_RESET_TAIL: return 9;
			REG_SLOT_LOW, REG_RECOVERY: return 4;
			REG_WRITE_HOLD, REG_READ_TAIL: return 7;
			REG_READ_SAMPLE: return 6;
			default: return 0;
		endcase
	endfunction

	function automatic logic [9:0] reg_default(input logic [2:0] idx);
		case (idx)
			REG_RESET_LOW: return 10'(RESET_LOW_DEFAULT);
			REG_PRESENCE_WAIT: return 10'(PRESENCE_WAIT_DEFAULT);
			REG_RESET_TAIL: return 10'(RESET_TAIL_DEFAULT);
			REG_SLOT_LOW: return 10'(SLOT_LOW_DEFAULT);
			REG_WRITE_HOLD: return 10'(WRITE_HOLD_DEFAULT);
			REG_RECOVERY: return 10'(RECOVERY_DEFAULT);
			REG_READ_SAMPLE: return 10'(READ_SAMPLE_DEFAULT);
			default: return 10'(READ_TAIL_DEFAULT);
		endcase
	endfunction

	// A zero in a timing register still lasts one tick.
	function automatic logic [9:0] slot_len(input logic [2:0] idx);
		return (timing[idx] == '0) ? 10'd1 : timing[idx];
	endfunction

	// Advance the sequencer shadow by one tick and return the bus result it yields.
	function automatic owbm_res_t bus_tick(input logic [2:0] cmd, input logic [7:0] wd,
		input logic line_lvl);
		owbm_res_t r;
		logic last;
		logic finish;
		r = '0;
		finish = 1'b0;
		// Take a new command only while idle.
		if (seq_phase == PH_IDLE && cmd >= OP_RESET && cmd <= OP_READ_BIT) begin
			seq_op = cmd;
			if (cmd == OP_RESET) begin
				seq_phase = PH_RST_LOW;
				slot_left = slot_len(REG_RESET_LOW);
			end else begin
				seq_phase = PH_SLOT_LOW;
				slot_left = slot_len(REG_SLOT_LOW);
				bits_to_go = (cmd == OP_READ_BIT) ? 1 : BYTE_BITS;
				shifter = (cmd == OP_WRITE) ? wd : 8'h00;
			end
		end
		if (seq_phase != PH_IDLE) begin
			r.busy_res = 1'b1;
			last = (slot_left <= 10'd1);
			if (!last)
				slot_left = slot_left - 10'd1;
			case (seq_phase)
				PH_RST_LOW: begin
					r.drive_low = 1'b1;
					if (last) begin
						seq_phase = PH_RST_WAIT;
						slot_left = slot_len(REG_PRESENCE_WAIT);
					end
				end
				PH_RST_WAIT: begin
					// A device answers by holding the line low at the sample.
					if (last) begin
						present = ~line_lvl;
						seq_phase = PH_RST_TAIL;
						slot_left = slot_len(REG_RESET_TAIL);
					end
				end
				PH_RST_TAIL: begin
					if (last)
						finish = 1'b1;
				end
				PH_SLOT_LOW: begin
					r.drive_low = 1'b1;
					if (last) begin
						seq_phase = PH_SLOT_MID;
						slot_left = (seq_op == OP_WRITE) ? slot_len(REG_WRITE_HOLD)
							: slot_len(REG_READ_SAMPLE);
					end
				end
				PH_SLOT_MID: begin
					// A one bit is sent by releasing the line.
					if (seq_op == OP_WRITE)
						r.drive_low = ~shifter[0];
					if (last) begin
						if (seq_op == OP_READ_BIT)
							shifter = {7'b0, line_lvl};
						else if (seq_op != OP_WRITE)
							shifter = (shifter >> 1) | (8'(line_lvl) << (BYTE_BITS - 1));
						seq_phase = PH_SLOT_END;
						slot_left = (seq_op == OP_WRITE) ? slot_len(REG_RECOVERY)
							: slot_len(REG_READ_TAIL);
					end
				end
				default: begin
					if (last) begin
						if (seq_op == OP_WRITE)
							shifter = shifter >> 1;
						if (bits_to_go <= 1) begin
							bits_to_go = 0;
							finish = 1'b1;
						end else begin
							bits_to_go--;
							seq_phase = PH_SLOT_LOW;
							slot_left = slot_len(REG_SLOT_LOW);
						end
					end
				end
			endcase
			if (finish) begin
				r.done_res = 1'b1;
				if (seq_op == OP_READ_BYTE || seq_op == OP_READ_BIT)
					r.read_data = shifter;
				seq_phase = PH_IDLE;
				slot_left = '0;
			end
		end
		r.presence = present;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			fail_count++;
		end
	endtask

	function automatic logic line_for(input line_mode_e m);
		case (m)
			LINE_LOW: return 1'b0;
			LINE_HIGH: return 1'b1;
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Offer one tick item and hold it until the block takes it. Enter and leave at a
	// rising edge; ready is looked at on the falling edge before the accepting edge.
	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wd, input logic line_lvl);
		int gap;
		bit taken;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= cmd;
		cmd_ch.write_data <= wd;
		cmd_ch.line_in <= line_lvl;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			if (cmd_ch.ready) begin
				taken = 1;
				if (seq_phase == PH_IDLE) begin
					case (cmd)
						OP_RESET: n_resets++;
						OP_WRITE: n_writes++;
						OP_READ_BYTE: n_read_bytes++;
						OP_READ_BIT: n_read_bits++;
						default: ;
					endcase
				end
				bus_results_due.push_back(bus_tick(cmd, wd, line_lvl));
				ticks_sent++;
			end
			@(posedge clk);
		end
	endtask

	// Issue a command, then keep ticking until it completes. Busy ticks carry stray
	// commands and data, which the block must ignore.
	task automatic run_cmd(input logic [2:0] op, input logic [7:0] wd, input line_mode_e m);
		send_tick(op, wd, line_for(m));
		while (seq_phase != PH_IDLE)
			send_tick($urandom_range(0, 1) ? 3'($urandom_range(0, OP_LAST_CODE)) : OP_TICK,
				8'($urandom), line_for(m));
	endtask

	task automatic drain_results();
		while (bus_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_transfer(input logic write, input logic [2:0] idx,
		input logic [31:0] wdata, output logic [31:0] rdata);
		bit taken;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = pready;
			rdata = prdata;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_timing(input logic [2:0] idx, input logic [9:0] value);
		logic [31:0] rd;
		apb_transfer(1'b1, idx, 32'(value), rd);
		timing[idx] = value;
		apb_transfer(1'b0, idx, '0, rd);
		check_field($sformatf("register %0d readback", idx), 32'(value), rd);
	endtask

	// Stop offering ticks, let the block go idle, then load all eight timing registers.
	task automatic program_timing(input timing_pick_e pick);
		int w;
		int v;
		cmd_ch.valid <= 1'b0;
		drain_results();
		for (int i = 0; i < 8; i++) begin
			w = reg_width(3'(i));
			case (pick)
				PICK_ZERO: v = 0;
				PICK_ONE: v = 1;
				PICK_MAX: v = (1 << w) - 1;
				PICK_DEFAULT: v = int'(reg_default(3'(i)));
				PICK_SMALL: v = $urandom_range(1, 4);
				default: v = ($urandom_range(0, 23) == 0) ? $urandom_range(0, (1 << w) - 1)
					: $urandom_range(0, 5);
			endcase
			write_timing(3'(i), 10'(v));
		end
	endtask

	task automatic test_register_defaults();
		logic [31:0] rd;
		for (int i = 0; i < 8; i++) begin
			apb_transfer(1'b0, 3'(i), '0, rd);
			check_field($sformatf("register %0d after reset", i), 32'(reg_default(3'(i))), rd);
		end
	endtask

	// Bus timings as they come out of reset.
	task automatic test_default_timing();
		tx_gap_max = 17;
		rx_gap_max = 17;
		run_cmd(OP_WRITE, 8'hA5, LINE_RANDOM);
		run_cmd(OP_READ_BIT, 8'h00, LINE_HIGH);
	endtask

	// One-tick phases: every operation, both presence answers, extreme bytes.
	task automatic test_short_timing();
		program_timing(PICK_ONE);
		run_cmd(OP_RESET, 8'hFF, LINE_LOW);
		run_cmd(OP_RESET, 8'h00, LINE_HIGH);
		run_cmd(OP_WRITE, 8'h00, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'hFF, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'h5A, LINE_RANDOM);
		run_cmd(OP_READ_BYTE, 8'hFF, LINE_LOW);
		run_cmd(OP_READ_BYTE, 8'h00, LINE_HIGH);
		run_cmd(OP_READ_BYTE, 8'h00, LINE_RANDOM);
		run_cmd(OP_READ_BIT, 8'h00, LINE_LOW);
		run_cmd(OP_READ_BIT, 8'h00, LINE_HIGH);
		// Plain tick and the spare codes leave the block idle.
		for (int c = OP_TICK; c <= OP_LAST_CODE; c++) begin
			if (c == OP_TICK || c > OP_READ_BIT)
				run_cmd(3'(c), 8'($urandom), LINE_RANDOM);
		end
	endtask

	// Zero in every register behaves as a one-tick phase.
	task automatic test_zero_timing();
		program_timing(PICK_ZERO);
		run_cmd(OP_RESET, 8'h00, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'hC3, LINE_RANDOM);
		run_cmd(OP_READ_BYTE, 8'h00, LINE_RANDOM);
		run_cmd(OP_READ_BIT, 8'h00, LINE_RANDOM);
	endtask

	// Longest slot phases the registers allow, on a single-bit read; run without idling
	// to keep the cycle count down.
	task automatic test_long_timing();
		program_timing(PICK_MAX);
		tx_gap_max = 0;
		rx_gap_max = 0;
		run_cmd(OP_READ_BIT, 8'h00, LINE_RANDOM);
	endtask

	// Stall the result side for a long stretch while ticks keep coming, so the input
	// stage fills and the block must drop ready without losing or repeating a tick.
	task automatic test_backpressure();
		program_timing(PICK_SMALL);
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_hold_cycles = 160;
		run_cmd(OP_WRITE, 8'($urandom), LINE_RANDOM);
		run_cmd(OP_READ_BYTE, 8'h00, LINE_RANDOM);
		run_cmd(OP_RESET, 8'h00, LINE_RANDOM);
		run_cmd(OP_READ_BIT, 8'h00, LINE_RANDOM);
	endtask

	// Batches of random commands, each batch under fresh timings and idling.
	task automatic test_random_traffic();
		int unsigned start;
		logic [2:0] op;
		start = ticks_sent;
		while (ticks_sent - start < RANDOM_TICKS) begin
			program_timing(PICK_MIXED);
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
			repeat ($urandom_range(4, 12)) begin
				if (ticks_sent - start < RANDOM_TICKS) begin
					// Favor real commands; the rest draw from every code, plain and spare ticks included.
					if ($urandom_range(0, 3) != 0)
						op = 3'($urandom_range(OP_RESET, OP_READ_BIT));
					else
						op = 3'($urandom_range(0, OP_LAST_CODE));
					run_cmd(op, 8'($urandom), line_mode_e'($urandom_range(0, 2)));
				end
			end
		end
	endtask

	// Result side: stall a random number of cycles per item, or for a requested hold,
	// then compare the item taken against the oldest prediction.
	initial begin : result_checker
		int gap;
		bit taken;
		owbm_res_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
			if (rx_hold_cycles != 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			taken = 0;
			while (!taken) begin
				@(negedge clk);
				if (res_ch.valid) begin
					taken = 1;
					results_checked++;
					if (bus_results_due.size() == 0) begin
						$error("result item with no tick outstanding");
						fail_count++;
					end else begin
						want = bus_results_due.pop_front();
						check_field("drive_low", 32'(want.drive_low), 32'(res_ch.drive_low));
						check_field("busy_res", 32'(want.busy_res), 32'(res_ch.busy_res));
						check_field("done_res", 32'(want.done_res), 32'(res_ch.done_res));
						check_field("read_data", 32'(want.read_data), 32'(res_ch.read_data));
						check_field("presence", 32'(want.presence), 32'(res_ch.presence));
					end
				end
				@(posedge clk);
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		// Hold every input at a known value, then pulse reset once.
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.cmd <= OP_TICK;
		cmd_ch.write_data <= '0;
		cmd_ch.line_in <= 1'b1;
		res_ch.ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < 8; i++)
			timing[i] = reg_default(3'(i));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_defaults();
		test_default_timing();
		test_short_timing();
		test_zero_timing();
		test_long_timing();
		test_backpressure();
		test_random_traffic();

		// Drop valid, collect what is owed, then keep watching for stray result items.
		cmd_ch.valid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d ticks and %0d result items checked", ticks_sent, results_checked);
		$display("Commands run: %0d resets, %0d byte writes, %0d byte reads, %0d bit reads",
			n_resets, n_writes, n_read_bytes, n_read_bits);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
